### hdl/kfr_pkg.sv
// ============================================================================
// kfr_pkg
// shared types and constants of the keyed fifo with removal
// ============================================================================
package kfr_pkg;

    localparam int KEY_W     = 64;
    localparam int IN_PAY_W  = 32;
    localparam int OUT_PAY_W = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 7;

    localparam logic [KEY_W-1:0] BAD_KEY = '1;

    localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
    localparam logic [OP_W-1:0] OP_REM   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADKEY  = 3'd4;

    typedef struct packed {
        logic enq;
        logic deq;
        logic rem_apply;
        logic cmp;
    } kfr_ctrl_t;

endpackage

### hdl/kfr_cell.sv
// ============================================================================
// kfr_cell
// one queue slot: holds a key and payload, compares against the search key,
// loads on enqueue and takes its younger neighbor's entry on a shift
// ============================================================================
module kfr_cell #(
    parameter int INDEX        = 0,
    parameter int PAYLOAD_BITS = 32,
    parameter int CNT_W        = 7
) (
    input  logic                        clk,
    input  kfr_pkg::kfr_ctrl_t          ctrl,
    input  logic                        sel,
    input  logic [CNT_W-1:0]            count,
    input  logic [kfr_pkg::KEY_W-1:0]   in_key,
    input  logic [PAYLOAD_BITS-1:0]     in_payload,
    input  logic [kfr_pkg::KEY_W-1:0]   search_key,
    input  logic [kfr_pkg::KEY_W-1:0]   nbr_key,
    input  logic [PAYLOAD_BITS-1:0]     nbr_payload,
    output logic [kfr_pkg::KEY_W-1:0]   cell_key,
    output logic [PAYLOAD_BITS-1:0]     cell_payload,
    output logic                        hit
);

    logic [kfr_pkg::KEY_W-1:0] key_reg;
    logic [PAYLOAD_BITS-1:0]   payload_reg;
    logic                      hit_reg;
    logic                      occupied;
    logic                      shift;

    assign occupied = CNT_W'(INDEX) < count;
    assign shift    = ctrl.deq || (ctrl.rem_apply && sel);

    always_ff @(posedge clk)
    begin
        if (ctrl.enq && (count == CNT_W'(INDEX)))
        begin
            key_reg     <= in_key;
            payload_reg <= in_payload;
        end
        else if (shift)
        begin
            key_reg     <= nbr_key;
            payload_reg <= nbr_payload;
        end
        if (ctrl.cmp)
        begin
            hit_reg <= occupied && (key_reg == search_key);
        end
    end

    assign cell_key     = key_reg;
    assign cell_payload = payload_reg;
    assign hit          = hit_reg;

endmodule

### hdl/keyed_fifo_with_removal.sv
// ============================================================================
// keyed_fifo_with_removal
// ordered queue of key/payload entries with enqueue, dequeue, remove by key
// and clear, built as a shifting row of slot cells
// ============================================================================
// usage:
//   input channel carries op, key and payload; output channel carries
//   status, out_key, out_payload and occupancy, one result per transaction.
//   enqueue, dequeue and clear finish in the accept cycle; the result is
//   registered and valid the next cycle, and a new transaction is taken
//   every cycle while the output drains.
//   remove steps through the match, prefix and apply states: every cell
//   compares its key in parallel into a hit bit, a prefix-or over the hit
//   bits marks the first match and all slots behind it, then the marked
//   cells shift forward one slot and the result is registered.
//   input stall is high during a remove and whenever a held result is
//   stalled by the receiver; a stalled result holds its value.
//   reset empties the queue and drops any pending result; slot contents are
//   not cleared, only slots below the entry count are ever read.
// ============================================================================
module keyed_fifo_with_removal #(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [kfr_pkg::OP_W-1:0]           op,
    input  logic [kfr_pkg::KEY_W-1:0]          key,
    input  logic [kfr_pkg::IN_PAY_W-1:0]       payload,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [kfr_pkg::STATUS_W-1:0]       status,
    output logic [kfr_pkg::KEY_W-1:0]          out_key,
    output logic [kfr_pkg::OUT_PAY_W-1:0]      out_payload,
    output logic [kfr_pkg::OCC_W-1:0]          occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LOG_D = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PREFIX,
        ST_APPLY
    } state_t;

    state_t                           state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             out_valid_reg, out_valid_next;
    logic [kfr_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [kfr_pkg::KEY_W-1:0]        out_key_reg, out_key_next;
    logic [PAYLOAD_BITS-1:0]          out_pay_reg, out_pay_next;
    logic [kfr_pkg::OCC_W-1:0]        occ_reg;
    logic [kfr_pkg::KEY_W-1:0]        search_reg;
    logic [DEPTH-1:0]                 sel_reg, sel_next;

    logic [kfr_pkg::KEY_W-1:0]        cell_key [DEPTH];
    logic [PAYLOAD_BITS-1:0]          cell_pay [DEPTH];
    logic [DEPTH-1:0]                 hits;
    logic [DEPTH-1:0]                 first;
    logic [kfr_pkg::KEY_W-1:0]        ext_key;
    logic [PAYLOAD_BITS-1:0]          ext_pay;
    logic [PAYLOAD_BITS-1:0]          in_pay;

    kfr_pkg::kfr_ctrl_t               ctrl;
    logic                             take;
    logic                             out_free;
    logic                             res_load;
    logic                             search_load;

    assign in_pay   = PAYLOAD_BITS'(payload);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign take     = in_valid && !in_stall;

    // slot row
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [kfr_pkg::KEY_W-1:0] nbr_key;
            logic [PAYLOAD_BITS-1:0]   nbr_pay;
            if (g == DEPTH - 1)
            begin : g_last
                assign nbr_key = '0;
                assign nbr_pay = '0;
            end
            else
            begin : g_mid
                assign nbr_key = cell_key[g+1];
                assign nbr_pay = cell_pay[g+1];
            end
            kfr_cell #(
                .INDEX        (g),
                .PAYLOAD_BITS (PAYLOAD_BITS),
                .CNT_W        (CNT_W)
            ) u_cell (
                .clk          (clk),
                .ctrl         (ctrl),
                .sel          (sel_reg[g]),
                .count        (count_reg),
                .in_key       (key),
                .in_payload   (in_pay),
                .search_key   (search_reg),
                .nbr_key      (nbr_key),
                .nbr_payload  (nbr_pay),
                .cell_key     (cell_key[g]),
                .cell_payload (cell_pay[g]),
                .hit          (hits[g])
            );
        end
    endgenerate

    // inclusive prefix-or: first match and every slot behind it
    always_comb
    begin
        sel_next = hits;
        for (int s = 0; s < LOG_D; s++)
        begin
            sel_next = sel_next | (sel_next << (1 << s));
        end
    end

    assign first = sel_reg & ~(sel_reg << 1);

    always_comb
    begin
        ext_key = '0;
        ext_pay = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                ext_key = ext_key | cell_key[i];
                ext_pay = ext_pay | cell_pay[i];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = kfr_pkg::ST_OK;
        out_key_next   = '0;
        out_pay_next   = '0;
        res_load       = 1'b0;
        search_load    = 1'b0;
        ctrl           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (op)
                        kfr_pkg::OP_ENQ:
                        begin
                            res_load = 1'b1;
                            if (key == kfr_pkg::BAD_KEY)
                            begin
                                status_next = kfr_pkg::ST_BADKEY;
                            end
                            else if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = kfr_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.enq   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        kfr_pkg::OP_DEQ:
                        begin
                            res_load = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = kfr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.deq     = 1'b1;
                                out_key_next = cell_key[0];
                                out_pay_next = cell_pay[0];
                                count_next   = count_reg - CNT_W'(1);
                            end
                        end
                        kfr_pkg::OP_REM:
                        begin
                            if (key == kfr_pkg::BAD_KEY)
                            begin
                                res_load    = 1'b1;
                                status_next = kfr_pkg::ST_BADKEY;
                            end
                            else if (count_reg == '0)
                            begin
                                res_load    = 1'b1;
                                status_next = kfr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                search_load = 1'b1;
                                state_next  = ST_MATCH;
                            end
                        end
                        default:
                        begin
                            res_load   = 1'b1;
                            count_next = '0;
                        end
                    endcase
                end
            end
            ST_MATCH:
            begin
                ctrl.cmp   = 1'b1;
                state_next = ST_PREFIX;
            end
            ST_PREFIX:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (|sel_reg)
                    begin
                        ctrl.rem_apply = 1'b1;
                        out_key_next   = ext_key;
                        out_pay_next   = ext_pay;
                        count_next     = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = kfr_pkg::ST_MISSING;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg  <= status_next;
            out_key_reg <= out_key_next;
            out_pay_reg <= out_pay_next;
            occ_reg     <= kfr_pkg::OCC_W'(count_next);
        end
        if (search_load)
        begin
            search_reg <= key;
        end
        if (state_reg == ST_PREFIX)
        begin
            sel_reg <= sel_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_payload = kfr_pkg::OUT_PAY_W'(out_pay_reg);
    assign occupancy   = occ_reg;

endmodule

### dv/tb_keyed_fifo_with_removal.sv
// ============================================================================
// tb_keyed_fifo_with_removal
// self-checking testbench for the keyed fifo with removal. a directed list
// covers the empty, duplicate key, missing key and all-ones key cases, a
// fill past full runs under one long receiver hold-off, then biased random
// fill and drain traffic runs under changing idle rates. every transaction
// is scored against a shadow copy of the queue.
// ============================================================================
module tb_keyed_fifo_with_removal;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = 64;
    localparam int PAYLOAD_BITS  = 32;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int LONG_HOLD     = 300;
    localparam int POOL_SIZE     = 20;
    localparam int PHASE_ITEMS   = 560;
    localparam int PRESSURE_ENQS = 70;

    typedef struct {
        logic [kfr_pkg::OP_W-1:0]     op;
        logic [kfr_pkg::KEY_W-1:0]    key;
        logic [kfr_pkg::IN_PAY_W-1:0] payload;
    } fifo_op_t;

    typedef struct {
        logic [kfr_pkg::KEY_W-1:0] key;
        logic [PAYLOAD_BITS-1:0]   payload;
    } fifo_entry_t;

    typedef struct {
        logic [kfr_pkg::STATUS_W-1:0]  status;
        logic [kfr_pkg::KEY_W-1:0]     key;
        logic [kfr_pkg::OUT_PAY_W-1:0] payload;
        logic [kfr_pkg::OCC_W-1:0]     occupancy;
    } op_response_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [kfr_pkg::OP_W-1:0]      op        = kfr_pkg::OP_ENQ;
    logic [kfr_pkg::KEY_W-1:0]     key       = '0;
    logic [kfr_pkg::IN_PAY_W-1:0]  payload   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [kfr_pkg::STATUS_W-1:0]  status;
    logic [kfr_pkg::KEY_W-1:0]     out_key;
    logic [kfr_pkg::OUT_PAY_W-1:0] out_payload;
    logic [kfr_pkg::OCC_W-1:0]     occupancy;

    fifo_op_t     ops_to_send[$];
    fifo_entry_t  held_entries[$];
    op_response_t responses_due[$];
    logic [kfr_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

    fifo_op_t     next_op;
    op_response_t due;
    int           tx_idle_pct   = 0;
    int           rx_idle_pct   = 0;
    int           hold_requests = 0;
    int           hold_served   = 0;
    int           hold_left     = 0;
    int           error_count   = 0;
    int           cycle_count   = 0;

    keyed_fifo_with_removal #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .key         (key),
        .payload     (payload),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_key     (out_key),
        .out_payload (out_payload),
        .occupancy   (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // shadow queue update for one accepted transaction
    function automatic op_response_t apply_fifo_op(
        input logic [kfr_pkg::OP_W-1:0]     code,
        input logic [kfr_pkg::KEY_W-1:0]    k,
        input logic [kfr_pkg::IN_PAY_W-1:0] p);
        op_response_t resp;
        fifo_entry_t  ent;
        int           idx;
        resp.status  = kfr_pkg::ST_OK;
        resp.key     = '0;
        resp.payload = '0;
        case (code)
            kfr_pkg::OP_ENQ:
            begin
                if (k == kfr_pkg::BAD_KEY)
                    resp.status = kfr_pkg::ST_BADKEY;
                else if (held_entries.size() >= DEPTH)
                    resp.status = kfr_pkg::ST_FULL;
                else
                begin
                    ent.key     = k;
                    ent.payload = PAYLOAD_BITS'(p);
                    held_entries.push_back(ent);
                end
            end
            kfr_pkg::OP_DEQ:
            begin
                if (held_entries.size() == 0)
                    resp.status = kfr_pkg::ST_EMPTY;
                else
                begin
                    ent          = held_entries.pop_front();
                    resp.key     = ent.key;
                    resp.payload = kfr_pkg::OUT_PAY_W'(ent.payload);
                end
            end
            kfr_pkg::OP_REM:
            begin
                if (k == kfr_pkg::BAD_KEY)
                    resp.status = kfr_pkg::ST_BADKEY;
                else if (held_entries.size() == 0)
                    resp.status = kfr_pkg::ST_EMPTY;
                else
                begin
                    resp.status = kfr_pkg::ST_MISSING;
                    idx = -1;
                    foreach (held_entries[i])
                        if (idx < 0 && held_entries[i].key == k)
                            idx = i;
                    if (idx >= 0)
                    begin
                        resp.status  = kfr_pkg::ST_OK;
                        resp.key     = held_entries[idx].key;
                        resp.payload = kfr_pkg::OUT_PAY_W'(held_entries[idx].payload);
                        held_entries.delete(idx);
                    end
                end
            end
            default:
            begin
                held_entries.delete();
            end
        endcase
        resp.occupancy = kfr_pkg::OCC_W'(held_entries.size());
        return resp;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= kfr_pkg::OP_ENQ;
            key      <= '0;
            payload  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                responses_due.push_back(apply_fifo_op(op, key, payload));
            if (!in_valid || !in_stall)
            begin
                if (ops_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    next_op  = ops_to_send.pop_front();
                    in_valid <= 1'b1;
                    op       <= next_op.op;
                    key      <= next_op.key;
                    payload  <= next_op.payload;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (responses_due.size() == 0)
                begin
                    $display("%0t: unexpected transaction, status %0d key %h payload %h occ %0d",
                             $time, status, out_key, out_payload, occupancy);
                    error_count++;
                end
                else
                begin
                    due = responses_due.pop_front();
                    if (status !== due.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, due.status, status);
                        error_count++;
                    end
                    if (out_key !== due.key)
                    begin
                        $display("%0t: out_key mismatch, expected %h, actual %h",
                                 $time, due.key, out_key);
                        error_count++;
                    end
                    if (out_payload !== due.payload)
                    begin
                        $display("%0t: out_payload mismatch, expected %h, actual %h",
                                 $time, due.payload, out_payload);
                        error_count++;
                    end
                    if (occupancy !== due.occupancy)
                    begin
                        $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                                 $time, due.occupancy, occupancy);
                        error_count++;
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic send_op(input logic [kfr_pkg::OP_W-1:0]     code,
                           input logic [kfr_pkg::KEY_W-1:0]    k,
                           input logic [kfr_pkg::IN_PAY_W-1:0] p);
        fifo_op_t item;
        item.op      = code;
        item.key     = k;
        item.payload = p;
        ops_to_send.push_back(item);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (ops_to_send.size() > 0 || in_valid || responses_due.size() > 0)
            @(negedge clk);
    endtask

    function automatic logic [kfr_pkg::KEY_W-1:0] pool_key();
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic fifo_op_t make_random_op(input bit fill_mode);
        fifo_op_t item;
        int       pick;
        pick         = $urandom_range(99);
        item.key     = {$urandom, $urandom};
        item.payload = $urandom;
        if (pick < (fill_mode ? 1 : 3))
            item.op = kfr_pkg::OP_CLEAR;
        else if (pick < (fill_mode ? 75 : 30))
            item.op = kfr_pkg::OP_ENQ;
        else if (pick < (fill_mode ? 85 : 62))
            item.op = kfr_pkg::OP_DEQ;
        else
            item.op = kfr_pkg::OP_REM;
        if (item.op == kfr_pkg::OP_ENQ || item.op == kfr_pkg::OP_REM)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                item.key = kfr_pkg::BAD_KEY;
            else if (pick < 80)
                item.key = pool_key();
        end
        if ($urandom_range(99) < 5)
            key_pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom};
        return item;
    endfunction

    task automatic run_random(input int count);
        int remaining;
        int seg_len;
        bit fill_mode;
        remaining = count;
        while (remaining > 0)
        begin
            seg_len   = $urandom_range(160, 40);
            fill_mode = 1'($urandom_range(1));
            if (seg_len > remaining)
                seg_len = remaining;
            repeat (seg_len)
                ops_to_send.push_back(make_random_op(fill_mode));
            remaining -= seg_len;
        end
    endtask

    initial
    begin
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        tx_idle_pct = 21;
        rx_idle_pct = 75;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corner cases
        send_op(kfr_pkg::OP_DEQ, '0, '0);
        send_op(kfr_pkg::OP_REM, 64'd5, '0);
        send_op(kfr_pkg::OP_REM, kfr_pkg::BAD_KEY, '0);
        send_op(kfr_pkg::OP_ENQ, kfr_pkg::BAD_KEY, 32'h1234_5678);
        send_op(kfr_pkg::OP_ENQ, '0, '0);
        send_op(kfr_pkg::OP_ENQ, 64'hffff_ffff_ffff_fffe, '1);
        send_op(kfr_pkg::OP_ENQ, 64'h0123_4567_89ab_cdef, 32'd1);
        send_op(kfr_pkg::OP_ENQ, 64'h0123_4567_89ab_cdef, 32'd2);
        send_op(kfr_pkg::OP_ENQ, 64'hfedc_ba98_7654_3210, 32'd3);
        send_op(kfr_pkg::OP_REM, 64'h0123_4567_89ab_cdef, '0);
        send_op(kfr_pkg::OP_REM, 64'h0000_0000_dead_beef, '0);
        send_op(kfr_pkg::OP_REM, kfr_pkg::BAD_KEY, '0);
        send_op(kfr_pkg::OP_REM, 64'hfedc_ba98_7654_3210, '0);
        send_op(kfr_pkg::OP_DEQ, '0, '0);
        send_op(kfr_pkg::OP_REM, 64'hffff_ffff_ffff_fffe, '0);
        send_op(kfr_pkg::OP_DEQ, '0, '0);
        send_op(kfr_pkg::OP_DEQ, '0, '0);
        send_op(kfr_pkg::OP_ENQ, 64'h8000_0000_0000_0000, 32'h8000_0000);
        send_op(kfr_pkg::OP_ENQ, 64'h1, 32'h1);
        send_op(kfr_pkg::OP_CLEAR, '0, '0);
        send_op(kfr_pkg::OP_CLEAR, '0, '0);
        send_op(kfr_pkg::OP_REM, '0, '0);
        send_op(kfr_pkg::OP_ENQ, 64'h5555_5555_5555_5555, 32'haaaa_aaaa);
        send_op(kfr_pkg::OP_REM, 64'h5555_5555_5555_5555, '0);
        wait_drained();

        // fill past full while the receiver holds off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        send_op(kfr_pkg::OP_CLEAR, '0, '0);
        repeat (PRESSURE_ENQS)
            send_op(kfr_pkg::OP_ENQ, {$urandom, $urandom}, $urandom);
        send_op(kfr_pkg::OP_ENQ, pool_key(), $urandom);
        send_op(kfr_pkg::OP_REM, pool_key(), '0);
        repeat (4)
            send_op(kfr_pkg::OP_DEQ, '0, '0);
        wait_drained();

        tx_idle_pct = 21;
        rx_idle_pct = 75;
        run_random(PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 75;
        rx_idle_pct = 21;
        run_random(PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_ITEMS);
        wait_drained();

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

endmodule
